// ===== rtl/bts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, codes and types of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int COORD_W = 18;   // signed coordinate, 16 fraction bits
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 16;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 8;    // integer texel position
  localparam int ADDR_W  = 18;   // computed row-major texel address
  localparam int CFG_IDX_W = 2;
  localparam int LANES   = 3;
  localparam int TAPS    = 4;

  localparam int MAX_TEXELS_DEF  = 65536;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // tap order: 0 (x0,y0), 1 (x1,y0), 2 (x1,y1), 3 (x0,y1)
  typedef struct packed {
    logic                        vld;
    logic                        smp;
    logic [TAPS-1:0][ADDR_W-1:0] addr;
    logic [TAPS-1:0]             oob;
    logic                        wr_ok;
    logic [IDX_W-1:0]            wr_idx;
    logic [RGB_W-1:0]            wr_rgb;
  } fetch_t;

endpackage
`default_nettype wire

// ===== rtl/bts_addr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bts_addr
// Coordinate clamp, scale by size-1, and generation of the four tap addresses.
// ----------------------------------------------------------------------------
module bts_addr #(
  parameter int MAX_TEXELS  = bts_pkg::MAX_TEXELS_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_vld,
  input  wire logic                         in_op,
  input  wire logic [bts_pkg::IDX_W-1:0]    in_idx,
  input  wire logic [bts_pkg::RGB_W-1:0]    in_rgb,
  input  wire logic [bts_pkg::COORD_W-1:0]  in_u,
  input  wire logic [bts_pkg::COORD_W-1:0]  in_v,
  input  wire logic [bts_pkg::SIZE_W-1:0]   cfg_w,
  input  wire logic [bts_pkg::SIZE_W-1:0]   cfg_h,
  output bts_pkg::fetch_t                   fetch,
  output logic [WEIGHT_BITS-1:0]            s_wt,
  output logic [WEIGHT_BITS-1:0]            t_wt
);
  import bts_pkg::*;

  localparam int PX_W = FRAC_W + 1 + POS_W;

  // stage a: clamp and scale
  logic [FRAC_W:0]       cu, cv;
  logic [SIZE_W-1:0]     ws, hs;
  logic [POS_W-1:0]      wm1, hm1;
  logic [PX_W-1:0]       px_r, px_nxt, py_r, py_nxt;
  logic [SIZE_W-1:0]     ws_r;
  logic                  vld_a_r, op_a_r;
  logic [IDX_W-1:0]      idx_a_r;
  logic [RGB_W-1:0]      rgb_a_r;

  function automatic logic [FRAC_W:0] clamp_coord(input logic [COORD_W-1:0] c);
    logic [FRAC_W:0] r;
    if (c[COORD_W-1]) r = '0;
    else if (c[COORD_W-2:0] > {1'b1, {FRAC_W{1'b0}}}) r = {1'b1, {FRAC_W{1'b0}}};
    else r = c[FRAC_W:0];
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] r;
    if (n < SIZE_MIN) r = SIZE_MIN;
    else if (n > SIZE_MAX) r = SIZE_MAX;
    else r = n;
    return r;
  endfunction

  always_comb begin
    cu  = clamp_coord(in_u);
    cv  = clamp_coord(in_v);
    ws  = clamp_size(cfg_w);
    hs  = clamp_size(cfg_h);
    wm1 = POS_W'(ws - SIZE_W'(1));
    hm1 = POS_W'(hs - SIZE_W'(1));
    px_nxt = PX_W'(cu * wm1);
    py_nxt = PX_W'(cv * hm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r  <= in_op;
      idx_a_r <= in_idx;
      rgb_a_r <= in_rgb;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      ws_r    <= ws;
    end
  end

  // stage b: floor, ceiling and row-major addresses
  logic [POS_W-1:0]  x0, y0;
  logic [FRAC_W-1:0] fx, fy;
  logic [SIZE_W-1:0] x1;
  logic [ADDR_W-1:0] row0, row1;
  fetch_t            fetch_nxt;
  logic              vld_b_r;
  fetch_t            fetch_r;

  always_comb begin
    x0   = px_r[FRAC_W +: POS_W];
    y0   = py_r[FRAC_W +: POS_W];
    fx   = px_r[FRAC_W-1:0];
    fy   = py_r[FRAC_W-1:0];
    x1   = SIZE_W'(x0) + SIZE_W'(fx != '0);
    row0 = ADDR_W'(ws_r * y0);
    row1 = row0 + ((fy != '0) ? ADDR_W'(ws_r) : '0);
    fetch_nxt.vld     = vld_a_r;
    fetch_nxt.smp     = (op_a_r == OP_SAMPLE);
    fetch_nxt.addr[0] = row0 + ADDR_W'(x0);
    fetch_nxt.addr[1] = row0 + ADDR_W'(x1);
    fetch_nxt.addr[2] = row1 + ADDR_W'(x1);
    fetch_nxt.addr[3] = row1 + ADDR_W'(x0);
    for (int i = 0; i < TAPS; i++) begin
      fetch_nxt.oob[i] = (32'(fetch_nxt.addr[i]) >= 32'(MAX_TEXELS));
    end
    fetch_nxt.wr_ok  = (32'(idx_a_r) < 32'(MAX_TEXELS));
    fetch_nxt.wr_idx = idx_a_r;
    fetch_nxt.wr_rgb = rgb_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fetch_r <= fetch_nxt;
      s_wt    <= fx[FRAC_W-1 -: WEIGHT_BITS];
      t_wt    <= fy[FRAC_W-1 -: WEIGHT_BITS];
    end
  end

  always_comb begin
    fetch     = fetch_r;
    fetch.vld = vld_b_r;
  end

endmodule
`default_nettype wire

// ===== rtl/bts_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bts_mem
// Texel memory held as two copies, each with one write and two read ports.
// ----------------------------------------------------------------------------
module bts_mem #(
  parameter int MAX_TEXELS = bts_pkg::MAX_TEXELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire bts_pkg::fetch_t                        fetch,
  output logic [bts_pkg::TAPS-1:0][bts_pkg::RGB_W-1:0] texel
);
  import bts_pkg::*;

  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  logic [RGB_W-1:0] mem0 [MAX_TEXELS];
  logic [RGB_W-1:0] mem1 [MAX_TEXELS];
  logic [TAPS-1:0][RGB_W-1:0] rd_r;
  logic [TAPS-1:0]            oob_r;
  logic                       wr_en;

  assign wr_en = en && fetch.vld && !fetch.smp && fetch.wr_ok;

  // load words go to both copies
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[AW'(fetch.wr_idx)] <= fetch.wr_rgb;
      mem1[AW'(fetch.wr_idx)] <= fetch.wr_rgb;
    end
  end

  // registered reads, two taps per copy
  always_ff @(posedge clk) begin
    if (en) begin
      rd_r[0] <= mem0[AW'(fetch.addr[0])];
      rd_r[1] <= mem0[AW'(fetch.addr[1])];
      rd_r[2] <= mem1[AW'(fetch.addr[2])];
      rd_r[3] <= mem1[AW'(fetch.addr[3])];
      oob_r   <= fetch.oob;
    end
  end

  // addresses past the store read as black
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      texel[i] = oob_r[i] ? '0 : rd_r[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bts_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bts_lane
// One color channel: weighted tap products, then sum with rounding.
// ----------------------------------------------------------------------------
module bts_lane #(
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        en,
  input  wire logic [bts_pkg::TAPS-1:0][2*WEIGHT_BITS:0]   wts,
  input  wire logic [bts_pkg::TAPS-1:0][bts_pkg::CH_W-1:0] taps,
  output logic [bts_pkg::CH_W-1:0]                         chan
);
  import bts_pkg::*;

  localparam int PR_W  = 2 * WEIGHT_BITS + 1 + CH_W;
  localparam int SUM_W = PR_W + 2;

  logic [TAPS-1:0][PR_W-1:0] prod_r;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          q;

  // one multiplier per tap
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_r[i] <= PR_W'(wts[i] * taps[i]);
      end
    end
  end

  // sum, round half up, saturate to a byte
  always_comb begin
    sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3])
        + (SUM_W'(1) << (2 * WEIGHT_BITS - 1));
    q   = sum >> (2 * WEIGHT_BITS);
    chan = (q > SUM_W'(255)) ? {CH_W{1'b1}} : q[CH_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/bilinear_texture_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// RGB texel store, pipelined bilinear filter, one word per cycle unless held.
// ----------------------------------------------------------------------------
// Load words (op 0) write one texel; sample words (op 1) return one filtered
// color at the end of the pipeline, loads return nothing. The pipeline takes
// a new word every cycle: clamp and scale, address generation, texel memory
// read (two copies of the store give four read ports), one tap multiply per
// channel lane, then sum, rounding and the output register. It holds only
// while a result waits on out_ready. Texels must be loaded before they are
// sampled; the store has no clearing pass. Configuration is taken at any time
// but must only change while the pipeline is empty.
module bilinear_texture_sampler #(
  parameter int MAX_TEXELS  = bts_pkg::MAX_TEXELS_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_op,
  input  wire logic [bts_pkg::IDX_W-1:0]       in_texel_index,
  input  wire logic [bts_pkg::CH_W-1:0]        in_texel_red,
  input  wire logic [bts_pkg::CH_W-1:0]        in_texel_green,
  input  wire logic [bts_pkg::CH_W-1:0]        in_texel_blue,
  input  wire logic signed [bts_pkg::COORD_W-1:0] in_coord_u,
  input  wire logic signed [bts_pkg::COORD_W-1:0] in_coord_v,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bts_pkg::CH_W-1:0]             out_sample_red,
  output logic [bts_pkg::CH_W-1:0]             out_sample_green,
  output logic [bts_pkg::CH_W-1:0]             out_sample_blue,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bts_pkg::SIZE_W-1:0]      cfg_data
);
  import bts_pkg::*;

  localparam int WW = 2 * WEIGHT_BITS + 1;

  logic                   en;
  logic [SIZE_W-1:0]      tex_w_r, tex_h_r;
  fetch_t                 fetch;
  logic [WEIGHT_BITS-1:0] s_wt, t_wt;
  logic [TAPS-1:0][RGB_W-1:0] texel;
  logic [TAPS-1:0][WW-1:0]    wts_r, wts_nxt;
  logic                   vld_c_r, smp_c_r, vld_d_r, smp_d_r;
  logic [LANES-1:0][CH_W-1:0] chan;
  logic                   out_valid_r;
  logic [LANES-1:0][CH_W-1:0] out_r;

  // whole pipeline moves unless a result is stuck
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= SIZE_RESET;
      tex_h_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXTURE_WIDTH:  tex_w_r <= cfg_data;
        CFG_TEXTURE_HEIGHT: tex_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp, scale, addresses
  bts_addr #(.MAX_TEXELS(MAX_TEXELS), .WEIGHT_BITS(WEIGHT_BITS)) u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid && en),
    .in_op  (in_op),
    .in_idx (in_texel_index),
    .in_rgb ({in_texel_blue, in_texel_green, in_texel_red}),
    .in_u   (in_coord_u),
    .in_v   (in_coord_v),
    .cfg_w  (tex_w_r),
    .cfg_h  (tex_h_r),
    .fetch  (fetch),
    .s_wt   (s_wt),
    .t_wt   (t_wt)
  );

  // texel memory
  bts_mem #(.MAX_TEXELS(MAX_TEXELS)) u_mem (
    .clk   (clk),
    .en    (en),
    .fetch (fetch),
    .texel (texel)
  );

  // bilinear weights, alongside the memory read
  always_comb begin
    logic [WEIGHT_BITS:0] sw, tw, sc, tc;
    sw = (WEIGHT_BITS+1)'(s_wt);
    tw = (WEIGHT_BITS+1)'(t_wt);
    sc = ((WEIGHT_BITS+1)'(1) << WEIGHT_BITS) - sw;
    tc = ((WEIGHT_BITS+1)'(1) << WEIGHT_BITS) - tw;
    wts_nxt[0] = WW'(sc * tc);
    wts_nxt[1] = WW'(sw * tc);
    wts_nxt[2] = WW'(sw * tw);
    wts_nxt[3] = WW'(sc * tw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wts_r <= wts_nxt;
    end
  end

  // valid tracking past the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r     <= 1'b0;
      vld_d_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_c_r     <= fetch.vld;
      vld_d_r     <= vld_c_r;
      out_valid_r <= vld_d_r && smp_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp_c_r <= fetch.smp;
      smp_d_r <= smp_c_r;
    end
  end

  // channel lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [TAPS-1:0][CH_W-1:0] taps;
    always_comb begin
      for (int i = 0; i < TAPS; i++) begin
        taps[i] = texel[i][g*CH_W +: CH_W];
      end
    end
    bts_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
      .clk  (clk),
      .en   (en),
      .wts  (wts_r),
      .taps (taps),
      .chan (chan[g])
    );
  end

  // merge lanes into the result word
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= chan;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_red   = out_r[0];
  assign out_sample_green = out_r[1];
  assign out_sample_blue  = out_r[2];

endmodule
`default_nettype wire
